// ----- rtl/b64enc_pkg.sv -----
`default_nettype none

package b64enc_pkg;

    // ASCII code of the pad character.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Number of groups the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Index of the fourth character within a group.
    localparam logic [1:0] CHAR_IDX_LAST = 2'd3;

    // Byte counts of a group.
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    // One assembled group of up to three bytes, handed from front to back.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       last;
    } group_t;

    // Map a six-bit value onto the standard base64 alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/b64enc_front.sv -----
`default_nettype none

module b64enc_front (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire [7:0]              in_byte,
    input  wire                    in_last,
    output logic                   push,
    output b64enc_pkg::group_t     push_group,
    input  wire                    push_ready
);
    import b64enc_pkg::*;

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    logic       store;

    // Every beat is taken as long as the queue has room for a group.
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign store    = (cnt_reg != 2'd2) && !in_last;
    assign push     = accept && !store;

    // Assemble the group from the pending bytes and the new byte.
    always_comb begin
        push_group.b0     = (cnt_reg == 2'd0) ? in_byte : held0_reg;
        push_group.b1     = (cnt_reg == 2'd0) ? 8'h00 :
                            (cnt_reg == 2'd1) ? in_byte : held1_reg;
        push_group.b2     = (cnt_reg == 2'd2) ? in_byte : 8'h00;
        push_group.nbytes = cnt_reg + 2'd1;
        push_group.last   = in_last;
    end

    // Hold bytes until a group is complete or the message ends.
    always_comb begin
        held0_next = held0_reg;
        held1_next = held1_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            if (store) begin
                if (cnt_reg == 2'd0) begin
                    held0_next = in_byte;
                end else begin
                    held1_next = in_byte;
                end
                cnt_next = cnt_reg + 2'd1;
            end else begin
                cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // The pending count never reaches a full group.
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("front: pending count reached three");

    // A flushed group leaves nothing pending behind it.
    assert property (@(posedge aclk) disable iff (!aresetn) push |=> cnt_reg == 2'd0)
        else $error("front: bytes pending after a group was pushed");

    // A stored byte never produces a group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && store |-> !push)
        else $error("front: group pushed for a stored byte");

endmodule

`default_nettype wire

// ----- rtl/b64enc_queue.sv -----
`default_nettype none

module b64enc_queue (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push,
    input  wire b64enc_pkg::group_t push_group,
    output logic                   push_ready,
    input  wire                    pop,
    output logic                   pop_valid,
    output b64enc_pkg::group_t     pop_group
);
    import b64enc_pkg::*;

    localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);
    localparam logic [QUEUE_AW:0] ONE_COUNT  = (QUEUE_AW + 1)'(1);
    localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);

    group_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_group  = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + ONE_COUNT;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - ONE_COUNT;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_group;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill count stays within the depth.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= FULL_COUNT)
        else $error("queue: fill count beyond depth");

    // A group is never pushed into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> push_ready)
        else $error("queue: push while full");

    // An empty queue has its pointers together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue: pointers apart while empty");

endmodule

`default_nettype wire

// ----- rtl/b64enc_back.sv -----
`default_nettype none

module b64enc_back (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    grp_valid,
    input  wire b64enc_pkg::group_t grp,
    output logic                   grp_pop,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [7:0]             out_char,
    output logic                   out_eot
);
    import b64enc_pkg::*;

    group_t     grp_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg, char_next;
    logic       eot_reg, eot_next;
    logic       out_load;
    logic       emit;
    logic       emit_last;
    logic [5:0] sextet;

    // The output register loads when it is empty or being drained.
    assign out_load  = !valid_reg || out_ready;
    assign emit      = busy_reg && out_load;
    assign emit_last = emit && (idx_reg == CHAR_IDX_LAST);
    assign grp_pop   = grp_valid && (!busy_reg || emit_last);

    // Pick the six bits for the current character of the group.
    always_comb begin
        case (idx_reg)
            2'd0:    sextet = grp_reg.b0[7:2];
            2'd1:    sextet = {grp_reg.b0[1:0], grp_reg.b1[7:4]};
            2'd2:    sextet = {grp_reg.b1[3:0], grp_reg.b2[7:6]};
            default: sextet = grp_reg.b2[5:0];
        endcase
    end

    // Characters past the group's bytes become padding.
    always_comb begin
        char_next = sextet_char(sextet);
        if ((idx_reg == 2'd2) && (grp_reg.nbytes < NBYTES_TWO)) begin
            char_next = PAD_CHAR;
        end
        if ((idx_reg == CHAR_IDX_LAST) && (grp_reg.nbytes != NBYTES_THREE)) begin
            char_next = PAD_CHAR;
        end
        eot_next = grp_reg.last && (idx_reg == CHAR_IDX_LAST);
    end

    always_ff @(posedge aclk) begin
        if (grp_pop) begin
            grp_reg <= grp;
        end
        if (emit) begin
            char_reg <= char_next;
            eot_reg  <= eot_next;
        end
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (grp_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end else if (emit_last) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (out_load) begin
                valid_reg <= emit;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_eot   = eot_reg;

    // A new group is taken only when the current one is finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        grp_pop |-> !busy_reg || emit_last)
        else $error("back: group taken while one is in progress");

    // The end mark only follows the fourth character of a group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && (idx_reg != CHAR_IDX_LAST) |=> !eot_reg)
        else $error("back: end mark on an inner character");

    // A character is produced only from a group in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_reg) |-> $past(busy_reg))
        else $error("back: character without a group");

endmodule

`default_nettype wire

// ----- rtl/base64_stream_encoder_core.sv -----
`default_nettype none

// Base64 (RFC 4648) stream encoder. Bytes enter one beat at a time on the
// s_ channel, with s_is_last high on the final byte of a message; characters
// leave one beat at a time on the m_ channel, with m_end_of_text high on the
// final character, after any '=' padding. Every three bytes, or the partial
// group that ends a message, yield exactly four characters. The front takes
// a byte every cycle while a two-group queue has room; the back turns each
// group into four characters at one per cycle, unless m_ready stalls it,
// through a registered output, so a steady stream runs at four output beats
// per three input bytes, set by the one-character result channel.
module base64_stream_encoder_core (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [7:0]  s_data_byte,
    input  wire        s_is_last,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_char_code,
    output logic       m_end_of_text
);
    import b64enc_pkg::*;

    logic   push;
    group_t push_group;
    logic   push_ready;
    logic   pop;
    logic   pop_valid;
    group_t pop_group;

    // Front: collects bytes into groups.
    b64enc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_data_byte),
        .in_last    (s_is_last),
        .push       (push),
        .push_group (push_group),
        .push_ready (push_ready)
    );

    // Queue of assembled groups.
    b64enc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_group  (pop_group)
    );

    // Back: emits four characters per group.
    b64enc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (pop_valid),
        .grp       (pop_group),
        .grp_pop   (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_char  (m_char_code),
        .out_eot   (m_end_of_text)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_base64_stream_encoder_core.sv -----
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;

    import b64enc_pkg::PAD_CHAR;

    localparam int RANDOM_BYTES   = 430;
    localparam int SQUEEZE_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 32;
    localparam int REPORT_LIMIT   = 10;

    // One byte of a message waiting to be offered to the encoder.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    // One encoded character as it should leave the encoder.
    typedef struct {
        logic [7:0] code;
        logic       eot;
    } char_beat_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_is_last   = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_char_code;
    logic       m_end_of_text;

    msg_byte_t  byte_backlog[$];
    char_beat_t predicted_chars[$];
    msg_byte_t  next_byte;
    char_beat_t oldest_char;

    // Encoder state as the predictor sees it.
    logic [7:0] held_bytes[2] = '{8'h00, 8'h00};
    logic [1:0] held_count    = 2'd0;

    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    int bytes_total    = 0;
    int bytes_launched = 0;
    int bytes_accepted = 0;
    int chars_seen     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int squeeze_left   = 0;
    bit squeeze_done   = 1'b0;
    int error_count    = 0;

    base64_stream_encoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_end_of_text (m_end_of_text)
    );

    // Free-running clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    task automatic add_byte(input logic [7:0] data, input logic last);
        msg_byte_t item;
        item.data = data;
        item.last = last;
        byte_backlog.push_back(item);
        bytes_total++;
    endtask

    task automatic push_char(input logic [7:0] code, input logic eot);
        char_beat_t beat;
        beat.code = code;
        beat.eot  = eot;
        predicted_chars.push_back(beat);
    endtask

    // Advance the predicted encoder by one accepted byte and queue the
    // characters it releases.
    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        if (held_count < 2'd2 && !last) begin
            held_bytes[held_count] = b;
            held_count = held_count + 2'd1;
        end else begin
            case (held_count)
                2'd0: begin
                    g0 = b;
                    g1 = 8'h00;
                    g2 = 8'h00;
                end
                2'd1: begin
                    g0 = held_bytes[0];
                    g1 = b;
                    g2 = 8'h00;
                end
                default: begin
                    g0 = held_bytes[0];
                    g1 = held_bytes[1];
                    g2 = b;
                end
            endcase
            push_char(b64_char(g0[7:2]), 1'b0);
            push_char(b64_char({g0[1:0], g1[7:4]}), 1'b0);
            push_char((held_count >= 2'd1) ? b64_char({g1[3:0], g2[7:6]}) : PAD_CHAR, 1'b0);
            push_char((held_count == 2'd2) ? b64_char(g2[5:0]) : PAD_CHAR, last);
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            held_count    = 2'd0;
        end
    endtask

    // Sender: offers backlog bytes with random gaps and predicts each
    // accepted beat. Gaps are skipped while the receiver is squeezed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                encode_byte(s_data_byte, s_is_last);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (gap_left > 0 && squeeze_left == 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
                next_byte       = byte_backlog.pop_front();
                s_valid        <= 1'b1;
                s_data_byte    <= next_byte.data;
                s_is_last      <= next_byte.last;
                bytes_launched <= bytes_launched + 1;
                if (bytes_launched >= 200 && bytes_launched < 300) begin
                    gap_left <= 0;
                end else if ($urandom_range(0, 3) != 0) begin
                    gap_left <= 0;
                end else if ($urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(10, 30);
                end else begin
                    gap_left <= $urandom_range(1, 3);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, a quiet window with no stalls, and one long
    // hold-off that lets the encoder fill up and push back on its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_left   <= 0;
            squeeze_left <= 0;
            squeeze_done <= 1'b0;
        end else if (squeeze_left > 0) begin
            squeeze_left <= squeeze_left - 1;
            m_ready      <= 1'b0;
        end else if (!squeeze_done && chars_seen >= 120) begin
            squeeze_done <= 1'b1;
            squeeze_left <= SQUEEZE_CYCLES;
            m_ready      <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (chars_seen >= 600 && chars_seen < 900) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(15, 60);
            end else begin
                stall_left <= $urandom_range(0, 2);
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: every character beat is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chars_seen <= chars_seen + 1;
            if (predicted_chars.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("ERROR: unexpected character 0x%02h eot %0b",
                             m_char_code, m_end_of_text);
                end
            end else begin
                oldest_char = predicted_chars.pop_front();
                if (m_char_code !== oldest_char.code || m_end_of_text !== oldest_char.eot) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("ERROR: char %0d expected 0x%02h eot %0b, got 0x%02h eot %0b",
                                 chars_seen, oldest_char.code, oldest_char.eot,
                                 m_char_code, m_end_of_text);
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int msg_len;
        int random_count;
        random_count = 0;

        // Single-byte messages at both extremes.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        // Two-byte messages.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        // A full group that closes the message.
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        // Full groups mid-message, including the '/' and '+' codes, then a
        // two-byte tail.
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFB, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBE, 1'b0);
        add_byte(8'h4D, 1'b0);
        add_byte(8'h61, 1'b1);
        // A full group followed by a one-byte tail.
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h04, 1'b1);

        // Random messages, mostly short so that every tail length recurs.
        while (random_count < RANDOM_BYTES) begin
            if ($urandom_range(0, 4) == 0) begin
                msg_len = $urandom_range(13, 40);
            end else begin
                msg_len = $urandom_range(1, 12);
            end
            for (int i = 0; i < msg_len; i++) begin
                add_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
            end
            random_count += msg_len;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_accepted != bytes_total || predicted_chars.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder_core.sv
tb/sv/tb_base64_stream_encoder_core.sv
